// ===== sv/ced_pkg.sv =====
`default_nettype none
package ced_pkg;

   localparam int MaxTasks  = 16;
   localparam int MaxFrames = 16;
   localparam int MaxSlots  = 8;
   localparam int TaskW     = $clog2(MaxTasks);
   localparam int FrameW    = $clog2(MaxFrames);
   localparam int SlotW     = $clog2(MaxSlots);
   localparam int SumW      = 20;
   localparam logic [SumW-1:0] SumMax = '1;

   typedef enum logic [2:0] {
      OP_LOAD_WCET  = 3'd0,
      OP_LOAD_SLOT  = 3'd1,
      OP_TASK_DONE  = 3'd2,
      OP_APER_DONE  = 3'd3,
      OP_APER_REQ   = 3'd4,
      OP_FRAME_TICK = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_PER_MISS  = 3'd0,
      KIND_APER_MISS = 3'd1,
      KIND_APER_REL  = 3'd2,
      KIND_PER_REL   = 3'd3,
      KIND_PER_SKIP  = 3'd4,
      KIND_ANSWER    = 3'd5,
      KIND_ACK       = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      CSR_FRM_LEN    = 2'd0,
      CSR_NUM_FRAMES = 2'd1,
      CSR_TASK_CNT   = 2'd2,
      CSR_APER_WCET  = 2'd3
   } csr_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  task_index;
      logic [3:0]  frame_index;
      logic [2:0]  slot_index;
      logic [15:0] wcet_value;
      logic        last_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  out_task;
      logic [2:0]  out_slot;
      logic [3:0]  out_frame;
      logic [15:0] frames_needed;
      logic        no_slack;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/cyclic_executive_frame_dispatcher_top.sv =====
`default_nettype none
// Cyclic executive frame dispatcher. One transaction is taken at a time; req_ready
// is low while it is processed. Loads, done ops and unknown ops pass through an
// execute state that presents the ack and returns to idle. A frame tick walks the
// tasks (one per cycle, a busy task waiting for a free output register), then
// releases or misses a pending aperiodic job, then walks the frame's slots, each
// through a read state as the slot table read is registered, emitting one result
// per finding, or a single ack when nothing is found. An aperiodic request sums the
// frame slacks one per cycle, then divides the WCET minus one by the total with a
// shift-subtract divider (one quotient bit per cycle), then walks frames for the
// remainder; it answers without dividing when the total slack or the WCET is zero.
// Each result waits in the output register until taken, which can hold the sequencer.
module cyclic_executive_frame_dispatcher_top
   import ced_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_EXEC   = 10'b0000000010,
      ST_TASKS  = 10'b0000000100,
      ST_APER   = 10'b0000001000,
      ST_SLOTRD = 10'b0000010000,
      ST_SLOTS  = 10'b0000100000,
      ST_SUM    = 10'b0001000000,
      ST_DIV    = 10'b0010000000,
      ST_WALK   = 10'b0100000000,
      ST_WAIT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0] frm_len_ff;
   logic [4:0]  num_frames_ff, task_cnt_ff;
   logic [15:0] aper_wcet_ff;

   // block state
   logic [MaxTasks-1:0]  busy_ff, mark_ff;
   logic [15:0]          wcet_mem [MaxTasks];
   logic [TaskW-1:0]     slot_mem [MaxFrames*MaxSlots];
   logic [SlotW:0]       slot_cnt_ff [MaxFrames];
   logic [15:0]          slack_ff [MaxFrames];
   logic [SumW-1:0]      sum_ff;
   logic [FrameW-1:0]    next_frame_ff;
   logic                 aper_pend_ff, aper_busy_ff;

   // working registers
   req_type              req_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;
   logic [5:0]           idx_ff;
   logic                 emitted_ff;
   logic [TaskW-1:0]     slot_task_ff;
   logic [15:0]          wcet_rd_ff;
   logic [FrameW-1:0]    cur_ff;
   logic [19:0]          total_ff;
   logic [20:0]          rem_ff;
   logic [15:0]          quo_ff;
   logic [15:0]          dividend_ff;
   logic [4:0]           dcnt_ff;
   logic [19:0]          acc_ff;
   logic [31:0]          need_ff;

   logic [4:0] nf, nt;
   assign nf = (num_frames_ff == 5'd0) ? 5'd1 :
               (num_frames_ff > 5'(MaxFrames)) ? 5'(MaxFrames) : num_frames_ff;
   assign nt = (task_cnt_ff == 5'd0) ? 5'd1 :
               (task_cnt_ff > 5'(MaxTasks)) ? 5'(MaxTasks) : task_cnt_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic req_fire, rsp_free;
   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   logic [FrameW-1:0] start_frame;
   assign start_frame = ({1'b0, next_frame_ff} < nf) ? next_frame_ff : '0;

   logic [SlotW:0] cnt_cur;
   assign cnt_cur = (slot_cnt_ff[next_frame_ff] > (SlotW+1)'(MaxSlots)) ?
                    (SlotW+1)'(MaxSlots) : slot_cnt_ff[next_frame_ff];

   // busy tasks after the current one, for the last flag of a miss
   logic [MaxTasks-1:0] later_busy;
   always_comb begin
      for (int i = 0; i < MaxTasks; i++)
         later_busy[i] = busy_ff[i] && (6'(i) > idx_ff) && (5'(i) < nt);
   end

   logic miss_last, slot_last;
   assign miss_last = !(|later_busy) && !aper_pend_ff && (cnt_cur == '0);
   assign slot_last = ((idx_ff + 6'd1) == {2'b0, cnt_cur});

   // divider step: remainder shift and trial subtract
   logic [20:0] rem_sh;
   logic        rem_ge;
   assign rem_sh = {rem_ff[19:0], dividend_ff[15]};
   assign rem_ge = rem_sh >= {1'b0, total_ff};

   // sum with saturation for slot load
   logic [SumW:0] sum_add;
   assign sum_add = {1'b0, sum_ff} + (SumW+1)'(wcet_rd_ff);

   function automatic rsp_type mk(kind_type k, logic [3:0] t, logic [2:0] s,
                                  logic [3:0] f, logic [15:0] n, logic ns,
                                  logic l);
      rsp_type r;
      r.kind = k; r.out_task = t; r.out_slot = s; r.out_frame = f;
      r.frames_needed = n; r.no_slack = ns; r.last = l;
      return r;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frm_len_ff    <= 16'd100;
         num_frames_ff <= 5'd1;
         task_cnt_ff   <= 5'd16;
         aper_wcet_ff  <= 16'd0;
      end else if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_FRM_LEN:    frm_len_ff    <= csr_data;
            CSR_NUM_FRAMES: num_frames_ff <= csr_data[4:0];
            CSR_TASK_CNT:   task_cnt_ff   <= csr_data[4:0];
            CSR_APER_WCET:  aper_wcet_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // table memories
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC && req_ff.op == OP_LOAD_WCET &&
          {1'b0, req_ff.task_index} < nt)
         wcet_mem[req_ff.task_index] <= req_ff.wcet_value;
      if (state_ff == ST_EXEC && req_ff.op == OP_LOAD_SLOT &&
          {1'b0, req_ff.task_index} < nt)
         slot_mem[{req_ff.frame_index, req_ff.slot_index}] <= req_ff.task_index;
      if (req_fire)
         wcet_rd_ff <= wcet_mem[req_data.task_index];
      slot_task_ff <= slot_mem[{next_frame_ff, idx_ff[SlotW-1:0]}];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_EXEC;
         default:   ;
      endcase
   end

   // a result enters the output register this cycle
   logic rsp_set;
   always_comb begin
      rsp_set = 1'b0;
      if (rsp_free) begin
         unique case (state_ff)
            ST_EXEC:  rsp_set = (req_ff.op != OP_FRAME_TICK) && (req_ff.op != OP_APER_REQ);
            ST_TASKS: rsp_set = (idx_ff < {1'b0, nt}) && busy_ff[idx_ff[TaskW-1:0]];
            ST_APER:  rsp_set = aper_pend_ff;
            ST_SLOTS: rsp_set = (idx_ff < {2'b0, cnt_cur}) || !emitted_ff;
            ST_DIV:   rsp_set = (total_ff == '0) || (aper_wcet_ff == '0);
            ST_WALK:  rsp_set = ({1'b0, acc_ff} >= rem_ff);
            default:  rsp_set = 1'b0;
         endcase
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_set) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= '0;
         mark_ff       <= '0;
         for (int i = 0; i < MaxFrames; i++) begin
            slot_cnt_ff[i] <= '0;
            slack_ff[i]    <= '0;
         end
         sum_ff        <= '0;
         next_frame_ff <= '0;
         aper_pend_ff  <= 1'b0;
         aper_busy_ff  <= 1'b0;
         idx_ff        <= '0;
         emitted_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  req_ff     <= req_data;
                  state_ff   <= state_in;
                  idx_ff     <= '0;
                  emitted_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               if (req_ff.op == OP_FRAME_TICK) begin
                  state_ff <= ST_TASKS;
               end else if (req_ff.op == OP_APER_REQ) begin
                  aper_pend_ff <= 1'b1;
                  total_ff     <= '0;
                  state_ff     <= ST_SUM;
               end else if (rsp_free) begin
                  if (req_ff.op == OP_LOAD_SLOT && {1'b0, req_ff.task_index} < nt) begin
                     if (req_ff.last_slot) begin
                        slot_cnt_ff[req_ff.frame_index] <= {1'b0, req_ff.slot_index} + 1'b1;
                        slack_ff[req_ff.frame_index] <=
                           ((sum_add[SumW] ? SumMax : sum_add[SumW-1:0]) >=
                            SumW'(frm_len_ff)) ? 16'd0 :
                           frm_len_ff - sum_add[15:0];
                        sum_ff <= '0;
                     end else begin
                        sum_ff <= sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
                     end
                  end
                  if (req_ff.op == OP_TASK_DONE) busy_ff[req_ff.task_index] <= 1'b0;
                  if (req_ff.op == OP_APER_DONE) aper_busy_ff <= 1'b0;
                  rsp_ff <= mk(KIND_ACK, '0, '0, next_frame_ff, '0, 1'b0, 1'b1);
                  state_ff <= ST_IDLE;
               end
            end
            // one task per cycle unless a miss waits for the output register: report and mark misses
            ST_TASKS: begin
               if (idx_ff >= {1'b0, nt}) begin
                  idx_ff   <= '0;
                  state_ff <= ST_APER;
               end else if (!busy_ff[idx_ff[TaskW-1:0]]) begin
                  idx_ff <= idx_ff + 1'b1;
               end else if (rsp_free) begin
                  mark_ff[idx_ff[TaskW-1:0]] <= 1'b1;
                  rsp_ff <= mk(KIND_PER_MISS, idx_ff[TaskW-1:0], '0, next_frame_ff,
                               '0, 1'b0, miss_last);
                  emitted_ff   <= 1'b1;
                  idx_ff       <= idx_ff + 1'b1;
               end
            end
            ST_APER: begin
               if (!aper_pend_ff) begin
                  state_ff <= ST_SLOTRD;
               end else if (rsp_free) begin
                  aper_pend_ff <= 1'b0;
                  aper_busy_ff <= 1'b1;
                  rsp_ff <= mk(aper_busy_ff ? KIND_APER_MISS : KIND_APER_REL, '0, '0,
                               next_frame_ff, '0, 1'b0, cnt_cur == '0);
                  emitted_ff   <= 1'b1;
                  state_ff     <= ST_SLOTRD;
               end
            end
            // wait state for the registered slot table read
            ST_SLOTRD: state_ff <= ST_SLOTS;
            ST_SLOTS: begin
               if (rsp_free) begin
                  if (idx_ff >= {2'b0, cnt_cur}) begin
                     // quiet tick gives a single ack
                     if (!emitted_ff)
                        rsp_ff <= mk(KIND_ACK, '0, '0, next_frame_ff, '0, 1'b0, 1'b1);
                     next_frame_ff <= ({1'b0, next_frame_ff} + 5'd1 >= nf) ? '0 :
                                      next_frame_ff + 1'b1;
                     state_ff <= ST_WAIT;
                  end else begin
                     if (mark_ff[slot_task_ff]) begin
                        mark_ff[slot_task_ff] <= 1'b0;
                        rsp_ff <= mk(KIND_PER_SKIP, slot_task_ff, idx_ff[SlotW-1:0],
                                     next_frame_ff, '0, 1'b0, slot_last);
                     end else begin
                        busy_ff[slot_task_ff] <= 1'b1;
                        rsp_ff <= mk(KIND_PER_REL, slot_task_ff, idx_ff[SlotW-1:0],
                                     next_frame_ff, '0, 1'b0, slot_last);
                     end
                     emitted_ff   <= 1'b1;
                     idx_ff       <= idx_ff + 1'b1;
                     state_ff     <= ST_SLOTRD;
                  end
               end
            end
            // sum slack of all frames in use
            ST_SUM: begin
               if (idx_ff >= {1'b0, nf}) begin
                  rem_ff      <= '0;
                  quo_ff      <= '0;
                  dividend_ff <= aper_wcet_ff - 16'd1;
                  dcnt_ff     <= '0;
                  idx_ff      <= '0;
                  state_ff    <= ST_DIV;
               end else begin
                  total_ff <= total_ff + 20'(slack_ff[idx_ff[FrameW-1:0]]);
                  idx_ff   <= idx_ff + 1'b1;
               end
            end
            // one quotient bit per cycle
            ST_DIV: begin
               if (total_ff == '0 || aper_wcet_ff == '0) begin
                  if (rsp_free) begin
                     need_ff <= '0;
                     state_ff <= ST_WAIT;
                     rsp_ff <= mk(KIND_ANSWER, '0, '0, next_frame_ff, '0,
                                  total_ff == '0, 1'b1);
                  end
               end else if (dcnt_ff == 5'd16) begin
                  // rem = wcet - full*total = (wcet-1) mod total + 1
                  rem_ff  <= rem_ff + 21'd1;
                  need_ff <= 32'(quo_ff) * 32'(nf);
                  acc_ff  <= '0;
                  cur_ff  <= start_frame;
                  state_ff <= ST_WALK;
               end else begin
                  rem_ff      <= rem_ge ? rem_sh - {1'b0, total_ff} : rem_sh;
                  quo_ff      <= {quo_ff[14:0], rem_ge};
                  dividend_ff <= {dividend_ff[14:0], 1'b0};
                  dcnt_ff     <= dcnt_ff + 1'b1;
               end
            end
            // walk frames until accumulated slack covers the remainder
            ST_WALK: begin
               if ({1'b0, acc_ff} >= rem_ff) begin
                  if (rsp_free) begin
                     rsp_ff <= mk(KIND_ANSWER, '0, '0, next_frame_ff,
                                  (need_ff > 32'hFFFF) ? 16'hFFFF : need_ff[15:0],
                                  1'b0, 1'b1);
                     state_ff <= ST_WAIT;
                  end
               end else begin
                  acc_ff  <= acc_ff + 20'(slack_ff[cur_ff]);
                  need_ff <= need_ff + 32'd1;
                  cur_ff  <= ({1'b0, cur_ff} + 5'd1 >= nf) ? '0 : cur_ff + 1'b1;
               end
            end
            ST_WAIT: if (rsp_free) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import ced_pkg::*;

   // Scoreboard: mirrors the dispatcher state and queues the expected results
   class dispatch_scoreboard;
      bit [15:0] frm_len;
      bit [4:0]  num_frames;
      bit [4:0]  task_cnt;
      bit [15:0] aper_wcet;
      bit        busy[16];
      bit        mark[16];
      bit [15:0] wcet_tab[16];
      bit [3:0]  slot_task[128];
      bit [3:0]  slot_count[16];
      bit [15:0] slack[16];
      bit [19:0] wcet_sum;
      bit [3:0]  cur_frame;
      bit        aper_pending;
      bit        aper_busy;
      rsp_type   expected_q[$];
      int        errors;

      function void clear();
         frm_len = 100; num_frames = 1; task_cnt = 16; aper_wcet = 0;
         foreach (busy[i]) begin
            busy[i] = 0; mark[i] = 0; wcet_tab[i] = 0; slot_count[i] = 0; slack[i] = 0;
         end
         foreach (slot_task[i]) slot_task[i] = 0;
         wcet_sum = 0; cur_frame = 0; aper_pending = 0; aper_busy = 0;
         expected_q.delete(); errors = 0;
      endfunction

      function int frames_used();
         return (num_frames < 1) ? 1 : (num_frames > 16) ? 16 : num_frames;
      endfunction

      function int tasks_used();
         return (task_cnt < 1) ? 1 : (task_cnt > 16) ? 16 : task_cnt;
      endfunction

      function void write_reg(csr_type idx, bit [15:0] val);
         case (idx)
            CSR_FRM_LEN:    frm_len = val;
            CSR_NUM_FRAMES: num_frames = val[4:0];
            CSR_TASK_CNT:   task_cnt = val[4:0];
            CSR_APER_WCET:  aper_wcet = val;
         endcase
      endfunction

      function void push(kind_type k, int tsk, int slt, int frm, int need, bit nos);
         rsp_type r;
         r.kind = k; r.out_task = 4'(tsk); r.out_slot = 3'(slt); r.out_frame = 4'(frm);
         r.frames_needed = 16'(need); r.no_slack = nos; r.last = 0;
         expected_q.insert(expected_q.size(), r);
      endfunction

      // Note an accepted request and predict its results
      function void note_request(req_type q);
         int n0, nf, nt, f, start, t;
         longint total, full, remn, acc, cnt;
         bit [20:0] s;
         n0 = expected_q.size();
         nf = frames_used(); nt = tasks_used();
         case (q.op)
            OP_FRAME_TICK: begin
               f = cur_frame;
               for (int i = 0; i < nt; i++)
                  if (busy[i]) begin
                     mark[i] = 1; push(KIND_PER_MISS, i, 0, f, 0, 0);
                  end
               if (aper_pending) begin
                  aper_pending = 0;
                  if (aper_busy) push(KIND_APER_MISS, 0, 0, f, 0, 0);
                  else begin
                     aper_busy = 1; push(KIND_APER_REL, 0, 0, f, 0, 0);
                  end
               end
               for (int i = 0; i < ((slot_count[f] > 8) ? 8 : slot_count[f]); i++) begin
                  t = slot_task[f*8 + i];
                  if (!mark[t]) begin
                     busy[t] = 1; push(KIND_PER_REL, t, i, f, 0, 0);
                  end else begin
                     mark[t] = 0; push(KIND_PER_SKIP, t, i, f, 0, 0);
                  end
               end
               if (expected_q.size() == n0) push(KIND_ACK, 0, 0, f, 0, 0);
               f++;
               cur_frame = (f >= nf) ? 4'd0 : 4'(f);
            end
            OP_APER_REQ: begin
               aper_pending = 1;
               start = (cur_frame < nf) ? cur_frame : 0;
               total = 0;
               for (int i = 0; i < nf; i++) total += slack[i];
               cnt = 0;
               if (total != 0 && aper_wcet != 0) begin
                  full = (aper_wcet - 1) / total;
                  remn = aper_wcet - full * total;
                  acc = 0; cnt = full * nf; f = start;
                  while (acc < remn) begin
                     acc += slack[f]; cnt++; f++;
                     if (f >= nf) f = 0;
                  end
                  if (cnt > 65535) cnt = 65535;
               end
               push(KIND_ANSWER, 0, 0, cur_frame, int'(cnt), total == 0);
            end
            default: begin
               if (q.op == OP_LOAD_WCET) begin
                  if (q.task_index < nt) wcet_tab[q.task_index] = q.wcet_value;
               end else if (q.op == OP_LOAD_SLOT) begin
                  if (q.task_index < nt) begin
                     slot_task[q.frame_index*8 + q.slot_index] = q.task_index;
                     s = wcet_sum + wcet_tab[q.task_index];
                     wcet_sum = (s > 21'hFFFFF) ? 20'hFFFFF : s[19:0];
                     if (q.last_slot) begin
                        slot_count[q.frame_index] = 4'(q.slot_index + 1);
                        slack[q.frame_index] = (wcet_sum >= frm_len) ? 16'd0 :
                                               16'(frm_len - wcet_sum);
                        wcet_sum = 0;
                     end
                  end
               end else if (q.op == OP_TASK_DONE) busy[q.task_index] = 0;
               else if (q.op == OP_APER_DONE) aper_busy = 0;
               push(KIND_ACK, 0, 0, cur_frame, 0, 0);
            end
         endcase
         expected_q[expected_q.size()-1].last = 1;
      endfunction

      // Compare one result against the oldest expectation
      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         e = expected_q.pop_front();
         if (got !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h actual %h", e, got);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [1:0]  csr_index = 0;
   logic [15:0] csr_data = 0;

   dispatch_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   cyclic_executive_frame_dispatcher_top i_dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Result side: random stall, check each transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send(req_type q);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(q);
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_csr(csr_type idx, bit [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic req_type make_req(op_type o, int tsk, int frm, int slt,
                                        int w, bit ls);
      req_type q;
      q.op = o; q.task_index = 4'(tsk); q.frame_index = 4'(frm); q.slot_index = 3'(slt);
      q.wcet_value = 16'(w); q.last_slot = ls;
      return q;
   endfunction

   // Load every task wcet for the current task count
   task automatic load_wcets(int maxw);
      for (int t = 0; t < board.tasks_used(); t++)
         send(make_req(OP_LOAD_WCET, t, $urandom_range(15), $urandom_range(7),
                       $urandom_range(maxw), $urandom_range(1)));
   endtask

   // Load a whole frame: well-formed slot sequence ending with last_slot
   task automatic load_frame(int frm, int nslots);
      for (int s = 0; s < nslots; s++)
         send(make_req(OP_LOAD_SLOT, $urandom_range(board.tasks_used() - 1), frm, s,
                       $urandom, s == nslots - 1));
   endtask

   // Random item; never reads an unwritten table entry
   task automatic random_item();
      int r;
      req_type q;
      r = $urandom_range(99);
      q = req_type'($bits(req_type)'({$urandom, $urandom}));
      if (r < 15) q.op = OP_FRAME_TICK;
      else if (r < 30) q.op = OP_APER_REQ;
      else if (r < 45) q.op = OP_TASK_DONE;
      else if (r < 55) q.op = OP_APER_DONE;
      else if (r < 65) q.op = OP_LOAD_WCET;
      else if (r < 70) q.op = 3'(6 + $urandom_range(1));
      else begin
         load_frame($urandom_range(board.frames_used() - 1), 1 + $urandom_range(7));
         return;
      end
      send(q);
   endtask

   task automatic random_phase(int nitems, int sidle, int ridle);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      repeat (nitems) random_item();
   endtask

   initial begin
      board.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: defaults, quiet tick, zero-slack request, unknown ops
      send(make_req(OP_FRAME_TICK, 0, 0, 0, 0, 0));
      send(make_req(OP_APER_REQ, 0, 0, 0, 0, 0));
      send(make_req(op_type'(3'd6), 15, 15, 7, 16'hFFFF, 1));
      send(make_req(op_type'(3'd7), 0, 0, 0, 0, 0));
      drain();
      write_csr(CSR_TASK_CNT, 16);
      write_csr(CSR_NUM_FRAMES, 4);
      write_csr(CSR_FRM_LEN, 65535);
      write_csr(CSR_APER_WCET, 65535);
      load_wcets(0);
      send(make_req(OP_LOAD_WCET, 15, 0, 0, 16'hFFFF, 0));
      send(make_req(OP_LOAD_WCET, 14, 0, 0, 16'hFFFF, 0));
      // frame length exceeded: eight max wcets give zero slack
      for (int s = 0; s < 8; s++) send(make_req(OP_LOAD_SLOT, 15 - (s & 1), 3, s, 0, s == 7));
      send(make_req(OP_LOAD_SLOT, 0, 0, 0, 0, 1));
      send(make_req(OP_APER_REQ, 0, 0, 0, 0, 0));
      send(make_req(OP_FRAME_TICK, 0, 0, 0, 0, 0));
      send(make_req(OP_FRAME_TICK, 0, 0, 0, 0, 0));
      send(make_req(OP_TASK_DONE, 0, 0, 0, 0, 0));
      send(make_req(OP_APER_REQ, 0, 0, 0, 0, 0));
      send(make_req(OP_APER_DONE, 0, 0, 0, 0, 0));
      drain();

      // Stale frame index, bad load index, zero wcet request, tiny frame length
      write_csr(CSR_NUM_FRAMES, 1);
      write_csr(CSR_TASK_CNT, 0);
      write_csr(CSR_APER_WCET, 0);
      write_csr(CSR_FRM_LEN, 1);
      send(make_req(OP_LOAD_WCET, 5, 0, 0, 7, 0));
      send(make_req(OP_LOAD_SLOT, 9, 2, 1, 0, 1));
      send(make_req(OP_APER_REQ, 0, 0, 0, 0, 0));
      send(make_req(OP_FRAME_TICK, 0, 0, 0, 0, 0));
      drain();
      write_csr(CSR_NUM_FRAMES, 31);
      write_csr(CSR_TASK_CNT, 31);
      write_csr(CSR_APER_WCET, 65535);
      send(make_req(OP_APER_REQ, 0, 0, 0, 0, 0));
      drain();

      // Random phases with varied settings
      write_csr(CSR_NUM_FRAMES, 3);
      write_csr(CSR_TASK_CNT, 8);
      write_csr(CSR_FRM_LEN, 200);
      write_csr(CSR_APER_WCET, 150);
      load_wcets(60);
      random_phase(25, 19, 80);
      // hold off until all results are in
      drain();
      write_csr(CSR_NUM_FRAMES, 16);
      write_csr(CSR_TASK_CNT, 16);
      write_csr(CSR_FRM_LEN, 16'($urandom_range(1, 65535)));
      write_csr(CSR_APER_WCET, 16'($urandom));
      load_wcets(65535);
      random_phase(25, 80, 19);
      drain();
      write_csr(CSR_NUM_FRAMES, 16'($urandom_range(1, 16)));
      write_csr(CSR_TASK_CNT, 16'($urandom_range(1, 16)));
      write_csr(CSR_FRM_LEN, 1000);
      write_csr(CSR_APER_WCET, 16'($urandom_range(0, 3000)));
      load_wcets(300);
      random_phase(26, 0, 0);
      drain();

      if (board.errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/ced_pkg.sv
sv/cyclic_executive_frame_dispatcher_top.sv
bench/tb.sv
